// ===== sv/sfs_pkg.sv =====
package sfs_pkg;

  // block dimensions
  localparam int unsigned CHANNELS         = 8;
  localparam int unsigned TICKS_PER_USEC   = 15;
  localparam int unsigned RESET_PULSE_USEC = 100;

  localparam int unsigned CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PHASE_W = 5;
  localparam int unsigned USEC_W  = 16;
  localparam int unsigned TPU_W   = 8;
  localparam int unsigned TICK_W  = 24;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 4;

  localparam logic [PHASE_W-1:0] PAUSE_PHASE = PHASE_W'(CHANNELS + 1);
  localparam logic [CHAN_W-1:0]  CHAN_LIMIT  = CHAN_W'(CHANNELS);
  localparam logic [TPU_W-1:0]   TPU         = TPU_W'(TICKS_PER_USEC);

  // reset pulse length in ticks, and the countdown it loads (never zero)
  localparam logic [TICK_W-1:0] RP_TICKS = TICK_W'(RESET_PULSE_USEC * TICKS_PER_USEC);
  localparam logic [TICK_W-1:0] RP_COUNT = (RP_TICKS == '0) ? TICK_W'(1) : RP_TICKS;

  localparam logic [USEC_W-1:0] MID_PULSE_USEC = USEC_W'(1500);

  // register reset values
  localparam logic [USEC_W-1:0] MIN_PULSE_RST   = USEC_W'(900);
  localparam logic [USEC_W-1:0] MAX_PULSE_RST   = USEC_W'(2100);
  localparam logic [TICK_W-1:0] FRAME_TICKS_RST = TICK_W'(300000);
  localparam logic [USEC_W-1:0] START_DELAY_RST = USEC_W'(16'hFFFF);

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_MIN_PULSE   = 2'd0,
    REG_MAX_PULSE   = 2'd1,
    REG_FRAME_TICKS = 2'd2,
    REG_START_DELAY = 2'd3
  } reg_e;

  typedef struct packed {
    logic [USEC_W-1:0] min_pulse_usec;
    logic [USEC_W-1:0] max_pulse_usec;
    logic [TICK_W-1:0] frame_ticks;
    logic [USEC_W-1:0] start_delay_ticks;
  } cfg_t;

  // item held in the execute stage
  typedef struct packed {
    mode_e mode;
    logic  read_err;
  } exec_item_t;

  typedef struct packed {
    logic               reset_level;
    logic               clock_level;
    logic               clock_strobe;
    logic [PHASE_W-1:0] frame_phase;
    logic [USEC_W-1:0]  read_usec;
    logic               read_error;
  } res_t;

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

// ===== sv/sfs_if.sv =====
interface sfs_in_if import sfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CHAN_W-1:0] channel;
  logic [USEC_W-1:0] pulse_usec;

  modport source (output valid, mode, channel, pulse_usec, input ready);
  modport sink   (input valid, mode, channel, pulse_usec, output ready);
endinterface

interface sfs_out_if import sfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               reset_level;
  logic               clock_level;
  logic               clock_strobe;
  logic [PHASE_W-1:0] frame_phase;
  logic [USEC_W-1:0]  read_usec;
  logic               read_error;

  modport source (output valid, reset_level, clock_level, clock_strobe, frame_phase,
                  read_usec, read_error, input ready);
  modport sink   (input valid, reset_level, clock_level, clock_strobe, frame_phase,
                  read_usec, read_error, output ready);
endinterface

// ===== sv/sfs_cfg_regs.sv =====
module sfs_cfg_regs import sfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o,
  output logic              start_wr_o,
  output logic [USEC_W-1:0] start_delay_o
);

  cfg_t cfg_q;
  logic wr_en;
  reg_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse_usec    <= MIN_PULSE_RST;
      cfg_q.max_pulse_usec    <= MAX_PULSE_RST;
      cfg_q.frame_ticks       <= FRAME_TICKS_RST;
      cfg_q.start_delay_ticks <= START_DELAY_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MIN_PULSE:   cfg_q.min_pulse_usec    <= pwdata[USEC_W-1:0];
        REG_MAX_PULSE:   cfg_q.max_pulse_usec    <= pwdata[USEC_W-1:0];
        REG_FRAME_TICKS: cfg_q.frame_ticks       <= pwdata[TICK_W-1:0];
        REG_START_DELAY: cfg_q.start_delay_ticks <= pwdata[USEC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_PULSE:   prdata = DATA_W'(cfg_q.min_pulse_usec);
      REG_MAX_PULSE:   prdata = DATA_W'(cfg_q.max_pulse_usec);
      REG_FRAME_TICKS: prdata = DATA_W'(cfg_q.frame_ticks);
      REG_START_DELAY: prdata = DATA_W'(cfg_q.start_delay_ticks);
      default:         prdata = '0;
    endcase
  end

  // start delay write reloads the countdown until the first match
  assign start_wr_o    = wr_en && (reg_idx == REG_START_DELAY);
  assign start_delay_o = pwdata[USEC_W-1:0];
  assign cfg_o         = cfg_q;

endmodule

// ===== sv/sfs_width_store.sv =====
module sfs_width_store import sfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              wr_en_i,
  input  logic [CH_W-1:0]   wr_addr_i,
  input  logic [USEC_W-1:0] wr_usec_i,
  input  logic              rd_en_i,
  input  logic [CH_W-1:0]   rd_addr_i,
  output logic [USEC_W-1:0] rd_usec_o
);

  logic [USEC_W-1:0]   mem [CHANNELS];
  logic [CHANNELS-1:0] valid_q;
  logic [USEC_W-1:0]   rd_data_q;
  logic                rd_valid_q;
  logic [USEC_W-1:0]   raised;
  logic [USEC_W-1:0]   clamped;

  // raise to min first, then lower to max
  assign raised  = (wr_usec_i < cfg_i.min_pulse_usec) ? cfg_i.min_pulse_usec : wr_usec_i;
  assign clamped = (raised > cfg_i.max_pulse_usec) ? cfg_i.max_pulse_usec : raised;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= clamped;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // never-written entry reads as the mid position
  assign rd_usec_o = rd_valid_q ? rd_data_q : MID_PULSE_USEC;

endmodule

// ===== sv/sfs_frame_ctrl.sv =====
module sfs_frame_ctrl import sfs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               start_wr_i,
  input  logic [USEC_W-1:0]  start_delay_i,
  input  logic               step_i,
  input  exec_item_t         item_i,
  input  logic [USEC_W-1:0]  width_usec_i,
  output res_t               res_o,
  output logic [PHASE_W-1:0] phase_next_o
);

  logic [TICK_W-1:0]  countdown_q, countdown_d;
  logic [TICK_W-1:0]  pause_q, pause_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               reset_line_q, reset_line_d;
  logic               clock_line_q, clock_line_d;
  logic               started_q, started_d;
  logic               strobe;

  logic [USEC_W+TPU_W-1:0] prod;
  logic [TICK_W-1:0]       w_ticks;
  logic [TICK_W:0]         w_plus_one;
  logic [TICK_W-1:0]       pause_taken;
  logic                    is_tick;

  assign prod        = {{TPU_W{1'b0}}, width_usec_i} * {{USEC_W{1'b0}}, TPU};
  assign w_ticks     = TICK_W'(prod);
  assign w_plus_one  = {1'b0, w_ticks} + (TICK_W+1)'(1);
  assign pause_taken = ({1'b0, pause_q} <= w_plus_one) ? TICK_W'(1) : (pause_q - w_ticks);
  assign is_tick     = step_i && (item_i.mode == MODE_TICK);

  always_comb begin
    countdown_d  = countdown_q;
    pause_d      = pause_q;
    phase_d      = phase_q;
    reset_line_d = reset_line_q;
    clock_line_d = clock_line_q;
    started_d    = started_q;
    strobe       = 1'b0;

    // the register takes the new value at this same edge, unless a tick executes and overrides it
    if (start_wr_i && !started_q) begin
      countdown_d = TICK_W'(start_delay_i);
    end

    if (is_tick) begin
      if (countdown_q <= TICK_W'(1)) begin
        started_d    = 1'b1;
        clock_line_d = 1'b1;
        if (phase_q == '0) begin
          // start of frame: reset pulse
          pause_d      = cfg_i.frame_ticks;
          countdown_d  = RP_COUNT;
          reset_line_d = 1'b1;
          phase_d      = PHASE_W'(1);
        end else if (phase_q == PHASE_W'(1)) begin
          // first channel pulse overlaps the reset pulse
          countdown_d  = (w_ticks > RP_TICKS) ? (w_ticks - RP_TICKS) : TICK_W'(1);
          pause_d      = pause_taken;
          reset_line_d = 1'b0;
          clock_line_d = 1'b0;
          phase_d      = PHASE_W'(2);
          strobe       = 1'b1;
        end else if (phase_q >= PAUSE_PHASE) begin
          // end of pause, back to start of frame
          countdown_d = at_least_one(pause_q);
          phase_d     = '0;
        end else begin
          countdown_d  = at_least_one(w_ticks);
          pause_d      = pause_taken;
          clock_line_d = 1'b0;
          phase_d      = phase_q + PHASE_W'(1);
          strobe       = 1'b1;
        end
      end else begin
        countdown_d = countdown_q - TICK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      countdown_q  <= TICK_W'(START_DELAY_RST);
      pause_q      <= FRAME_TICKS_RST;
      phase_q      <= '0;
      reset_line_q <= 1'b0;
      clock_line_q <= 1'b0;
      started_q    <= 1'b0;
    end else begin
      countdown_q  <= countdown_d;
      pause_q      <= pause_d;
      phase_q      <= phase_d;
      reset_line_q <= reset_line_d;
      clock_line_q <= clock_line_d;
      started_q    <= started_d;
    end
  end

  always_comb begin
    res_o.reset_level  = reset_line_d;
    res_o.clock_level  = clock_line_d;
    res_o.clock_strobe = strobe;
    res_o.frame_phase  = phase_d;
    res_o.read_usec    = ((item_i.mode == MODE_READ) && !item_i.read_err) ? width_usec_i : '0;
    res_o.read_error   = (item_i.mode == MODE_READ) && item_i.read_err;
  end

  assign phase_next_o = phase_d;

endmodule

// ===== sv/servo_frame_sequencer_unit.sv =====
// an accepted transaction is held in the execute register, and its result is captured
// in the output register when the execute stage steps
// throughput: one transaction per cycle while the output is not stalled, set by the width
// memory read and the countdown/phase update in the execute stage
// reset: asynchronous, active low; registers and sequencer state return to defaults,
// channel widths read back as 1500 through per-entry valid bits, no clearing pass
module servo_frame_sequencer_unit import sfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  sfs_in_if.sink            in_i,
  sfs_out_if.source         out_o
);

  cfg_t              cfg;
  logic              start_wr;
  logic [USEC_W-1:0] start_delay;

  // stage 0: accept, write clamped width or issue the width read
  mode_e              in_mode;
  logic               in_accept;
  logic               chan_ok;
  logic               wr_en;
  logic               rd_en;
  logic [CH_W-1:0]    rd_addr;
  logic [PHASE_W-1:0] phase_next;
  logic [PHASE_W-1:0] tick_entry;

  // stage 1: execute against the sequencer state
  logic               exec_valid_q;
  exec_item_t         exec_q;
  logic               exec_step;
  logic [USEC_W-1:0]  width_usec;
  res_t               exec_res;

  // output register
  logic               out_valid_q;
  res_t               out_q;

  sfs_cfg_regs u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .cfg_o         (cfg),
    .start_wr_o    (start_wr),
    .start_delay_o (start_delay)
  );

  // execute stage moves on when the output register is free or being drained
  assign exec_step = exec_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !exec_valid_q || exec_step;
  assign in_accept  = in_i.valid && in_i.ready;

  assign in_mode = mode_e'(in_i.mode);
  assign chan_ok = in_i.channel < CHAN_LIMIT;

  // a tick reads the width of the channel the phase will be in after the item
  // still in execute, so back-to-back ticks never see a stale phase
  assign tick_entry = phase_next - PHASE_W'(1);
  assign rd_addr    = (in_mode == MODE_TICK) ? tick_entry[CH_W-1:0] : in_i.channel[CH_W-1:0];

  // writes land at the accept edge, so any later read already sees them
  assign wr_en = in_accept && (in_mode == MODE_WRITE) && chan_ok;
  assign rd_en = in_accept && ((in_mode == MODE_TICK) || ((in_mode == MODE_READ) && chan_ok));

  sfs_width_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .wr_en_i   (wr_en),
    .wr_addr_i (in_i.channel[CH_W-1:0]),
    .wr_usec_i (in_i.pulse_usec),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_usec_o (width_usec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_valid_q <= 1'b0;
    end else if (in_accept) begin
      exec_valid_q <= 1'b1;
    end else if (exec_step) begin
      exec_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      exec_q.mode     <= in_mode;
      exec_q.read_err <= !chan_ok;
    end
  end

  sfs_frame_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .start_wr_i    (start_wr),
    .start_delay_i (start_delay),
    .step_i        (exec_step),
    .item_i        (exec_q),
    .width_usec_i  (width_usec),
    .res_o         (exec_res),
    .phase_next_o  (phase_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_step) begin
      out_q <= exec_res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.reset_level  = out_q.reset_level;
  assign out_o.clock_level  = out_q.clock_level;
  assign out_o.clock_strobe = out_q.clock_strobe;
  assign out_o.frame_phase  = out_q.frame_phase;
  assign out_o.read_usec    = out_q.read_usec;
  assign out_o.read_error   = out_q.read_error;

endmodule
